### hw/rtl/ddss_pkg.sv
// ----------------------------------------------------------------------------
// ddss_pkg
// shared widths, constants and the seven-segment decode for the scanner
// ----------------------------------------------------------------------------
package ddss_pkg;

  localparam int VALUE_W       = 10;
  localparam int DIGIT_W       = 4;
  localparam int SEG_W         = 7;
  localparam int NUM_POSITIONS = 6;
  localparam int POS_W         = 3;
  localparam int PLACE_W       = 2;
  localparam int NUM_CELLS     = 3;
  localparam int COUNT_W       = 4;
  localparam int DIGITS_PER_VALUE = 3;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [SEG_W-1:0]   seg_t;
  typedef logic [NUM_POSITIONS-1:0] enable_t;
  typedef logic [VALUE_W-1:0] value_t;

  // bit6 = a ... bit0 = g
  function automatic seg_t seg_of(input digit_t d);
    seg_t s;
    unique case (d)
      4'd0:    s = 7'b1111110;
      4'd1:    s = 7'b0110000;
      4'd2:    s = 7'b1101101;
      4'd3:    s = 7'b1111001;
      4'd4:    s = 7'b0110011;
      4'd5:    s = 7'b1011011;
      4'd6:    s = 7'b1011111;
      4'd7:    s = 7'b1110000;
      4'd8:    s = 7'b1111111;
      4'd9:    s = 7'b1111011;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

### hw/rtl/ddss_value_if.sv
// ----------------------------------------------------------------------------
// ddss_value_if
// input channel carrying the two values per refresh word
// ----------------------------------------------------------------------------
interface ddss_value_if;
  logic                 valid;
  logic                 ready;
  ddss_pkg::value_t     value_a;
  ddss_pkg::value_t     value_b;

  modport source (output valid, output value_a, output value_b, input ready);
  modport sink   (input valid, input value_a, input value_b, output ready);
endinterface

### hw/rtl/ddss_digit_if.sv
// ----------------------------------------------------------------------------
// ddss_digit_if
// output channel carrying digit enable and segment pattern per word
// ----------------------------------------------------------------------------
interface ddss_digit_if;
  logic                 valid;
  logic                 ready;
  ddss_pkg::enable_t    digit_enable;
  ddss_pkg::seg_t       segments;

  modport source (output valid, output digit_enable, output segments, input ready);
  modport sink   (input valid, input digit_enable, input segments, output ready);
endinterface

### hw/rtl/ddss_bcd_cell.sv
// ----------------------------------------------------------------------------
// ddss_bcd_cell
// one decimal digit of a shift-and-add-3 converter, bit-serial in and out
// ----------------------------------------------------------------------------
module ddss_bcd_cell (
  input  logic             clk,
  input  logic             clear,
  input  logic             shift,
  input  logic             bit_in,
  output logic             bit_out,
  output ddss_pkg::digit_t digit
);

  ddss_pkg::digit_t adj;

  // add 3 when the digit would overflow past 9 on doubling
  assign adj     = (digit >= ddss_pkg::digit_t'(5)) ? digit + ddss_pkg::digit_t'(3) : digit;
  assign bit_out = adj[ddss_pkg::DIGIT_W-1];

  always_ff @(posedge clk) begin
    if (clear) begin
      digit <= '0;
    end else if (shift) begin
      digit <= {adj[ddss_pkg::DIGIT_W-2:0], bit_in};
    end
  end

endmodule

### hw/rtl/dual_decimal_seven_segment_scanner_core.sv
// ----------------------------------------------------------------------------
// dual_decimal_seven_segment_scanner_core
// multiplexed two-number seven-segment display scanner
// ----------------------------------------------------------------------------
// Each input word (value_a, value_b) is one refresh tick. The scan position
// walks 0..5 and wraps; positions 0..2 show units, tens and hundreds of
// value_a, positions 3..5 the same of value_b, with leading zeros shown and a
// thousands digit dropped. The selected value is shifted one bit per cycle
// through a row of three decimal cells: load, conversion shifts, then an
// output register load, which waits while a prior result is not taken. One
// word is converted at a time; the next word is accepted while a finished
// result still waits in the output register.
module dual_decimal_seven_segment_scanner_core (
  input  logic clk,
  input  logic rst,
  ddss_value_if.sink   value_in,
  ddss_digit_if.source digit_out
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]                       state;
  logic [ddss_pkg::POS_W-1:0]       pos;
  logic [ddss_pkg::POS_W-1:0]       pos_next;
  logic [ddss_pkg::COUNT_W-1:0]     count;
  ddss_pkg::value_t                 shreg;
  logic [ddss_pkg::PLACE_W-1:0]     place;
  logic                             blank;
  ddss_pkg::enable_t                enable_hold;
  logic                             out_valid;
  ddss_pkg::enable_t                out_enable;
  ddss_pkg::seg_t                   out_segs;

  logic                             in_fire;
  logic                             out_fire;
  logic                             out_load;
  logic                             low_half;
  logic                             cell_clear;
  logic                             cell_shift;
  logic [ddss_pkg::NUM_CELLS:0]     chain;
  ddss_pkg::digit_t                 digits [ddss_pkg::NUM_CELLS];
  ddss_pkg::digit_t                 sel_digit;

  assign value_in.ready = (state == ST_IDLE);
  assign in_fire        = value_in.valid && value_in.ready;
  assign out_fire       = out_valid && digit_out.ready;
  assign out_load       = (state == ST_HOLD) && (!out_valid || digit_out.ready);
  assign low_half       = (pos < ddss_pkg::POS_W'(ddss_pkg::DIGITS_PER_VALUE));
  assign pos_next       = (pos >= ddss_pkg::POS_W'(ddss_pkg::NUM_POSITIONS - 1)) ?
                          '0 : pos + 1'b1;
  assign cell_clear     = in_fire;
  assign cell_shift     = (state == ST_CONV);

  assign chain[0] = shreg[ddss_pkg::VALUE_W-1];

  genvar gi;
  generate
    for (gi = 0; gi < ddss_pkg::NUM_CELLS; gi++) begin : g_cell
      ddss_bcd_cell u_cell (
        .clk     (clk),
        .clear   (cell_clear),
        .shift   (cell_shift),
        .bit_in  (chain[gi]),
        .bit_out (chain[gi+1]),
        .digit   (digits[gi])
      );
    end
  endgenerate

  always_comb begin
    case (place)
      2'd0:    sel_digit = digits[0];
      2'd1:    sel_digit = digits[1];
      2'd2:    sel_digit = digits[2];
      default: sel_digit = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pos       <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            pos   <= pos_next;
            count <= '0;
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          count <= count + 1'b1;
          if (count == ddss_pkg::COUNT_W'(ddss_pkg::VALUE_W - 1)) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      shreg       <= low_half ? value_in.value_a : value_in.value_b;
      place       <= low_half ? pos[ddss_pkg::PLACE_W-1:0]
                              : ddss_pkg::PLACE_W'(pos - ddss_pkg::POS_W'(3));
      blank       <= (pos >= ddss_pkg::POS_W'(ddss_pkg::NUM_POSITIONS));
      enable_hold <= ddss_pkg::enable_t'(1) << pos;
    end else if (cell_shift) begin
      shreg <= {shreg[ddss_pkg::VALUE_W-2:0], 1'b0};
    end
    if (out_load) begin
      out_enable <= blank ? '0 : enable_hold;
      out_segs   <= blank ? '0 : ddss_pkg::seg_of(sel_digit);
    end
  end

  assign digit_out.valid        = out_valid;
  assign digit_out.digit_enable = out_enable;
  assign digit_out.segments     = out_segs;

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos < ddss_pkg::POS_W'(ddss_pkg::NUM_POSITIONS))
    else $error("scan position out of range");

  a_onehot_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0(out_enable))
    else $error("digit enable not one-hot");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == ST_CONV) && (count == '0))
    else $error("accepted word did not start conversion");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !digit_out.ready) |=> $stable(out_segs) && $stable(out_enable))
    else $error("pending result overwritten");

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the dual decimal seven-segment scanner core
// ----------------------------------------------------------------------------
// Drives value pairs into the input channel and checks every digit word
// that the core emits. The scoreboard tracks the scan position on its own,
// picks the decimal digit that the position selects, and compares the
// one-hot enable and the segment pattern with each accepted output word.
// Both channels idle at random, with stretches of back-to-back transfers.
// The directed part covers every digit, the largest legal value and the
// values above 999, whose thousands digit is dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int RANDOM_WORDS = 1900;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 40;

  localparam ddss_pkg::seg_t GLYPHS [10] = '{
    7'h7E, 7'h30, 7'h6D, 7'h79, 7'h33,
    7'h5B, 7'h5F, 7'h70, 7'h7F, 7'h7B
  };

  typedef struct packed {
    ddss_pkg::enable_t digit_enable;
    ddss_pkg::seg_t    segments;
  } digit_word_t;

  class digit_scoreboard;
    logic [ddss_pkg::POS_W-1:0] scan_pos;
    digit_word_t                pending_digits[$];
    int                         errors;

    function new();
      scan_pos = '0;
      errors   = 0;
    endfunction

    function void note_word(ddss_pkg::value_t a, ddss_pkg::value_t b);
      int unsigned v;
      int unsigned place;
      int unsigned divisor;
      int unsigned digit;
      digit_word_t w;
      w = '0;
      if (scan_pos < ddss_pkg::NUM_POSITIONS) begin
        v       = (scan_pos < ddss_pkg::DIGITS_PER_VALUE) ? 32'(a) : 32'(b);
        place   = 32'(scan_pos) % ddss_pkg::DIGITS_PER_VALUE;
        divisor = (place == 0) ? 1 : (place == 1) ? 10 : 100;
        digit   = (v / divisor) % 10;
        w.digit_enable = ddss_pkg::enable_t'(1) << scan_pos;
        w.segments     = GLYPHS[digit];
      end
      scan_pos = (scan_pos >= ddss_pkg::NUM_POSITIONS - 1) ? '0 : scan_pos + 1'b1;
      pending_digits.push_back(w);
    endfunction

    function void check_digit(ddss_pkg::enable_t en, ddss_pkg::seg_t seg);
      digit_word_t w;
      if (pending_digits.size() == 0) begin
        $display("%0t: unexpected word, digit_enable %b segments %b", $time, en, seg);
        errors++;
        return;
      end
      w = pending_digits.pop_front();
      if (en !== w.digit_enable) begin
        $display("%0t: digit_enable expected %b got %b", $time, w.digit_enable, en);
        errors++;
      end
      if (seg !== w.segments) begin
        $display("%0t: segments expected %b got %b", $time, w.segments, seg);
        errors++;
      end
    endfunction

    function int waiting();
      return pending_digits.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic steady;
  int   cycles;

  digit_scoreboard board = new();

  ddss_value_if value_if ();
  ddss_digit_if digit_if ();

  dual_decimal_seven_segment_scanner_core DUT (
    .clk       (clk),
    .rst       (rst),
    .value_in  (value_if),
    .digit_out (digit_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic ddss_pkg::value_t random_value();
    if ($urandom_range(0, 9) == 0) return ddss_pkg::value_t'($urandom_range(1000, 1023));
    return ddss_pkg::value_t'($urandom_range(0, 999));
  endfunction

  task automatic send_word(ddss_pkg::value_t a, ddss_pkg::value_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      value_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    value_if.valid   <= 1'b1;
    value_if.value_a <= a;
    value_if.value_b <= b;
    @(posedge clk);
    while (!value_if.ready) @(posedge clk);
  endtask

  // monitor: both channels sampled at the edge where the word moves
  always @(posedge clk) begin
    if (!rst) begin
      if (value_if.valid && value_if.ready)
        board.note_word(value_if.value_a, value_if.value_b);
      if (digit_if.valid && digit_if.ready)
        board.check_digit(digit_if.digit_enable, digit_if.segments);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int stall;
    digit_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        digit_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      digit_if.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin
    ddss_pkg::value_t a;
    ddss_pkg::value_t b;
    cycles           = 0;
    steady           = 1'b0;
    rst              <= 1'b1;
    value_if.valid   <= 1'b0;
    value_if.value_a <= '0;
    value_if.value_b <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every digit on every place, then the extremes
    for (int i = 0; i < 20; i++) begin
      a = ddss_pkg::value_t'(111 * (i % 10));
      b = ddss_pkg::value_t'(111 * ((i + 3) % 10));
      send_word(a, b);
    end
    send_word(10'd1023, 10'd1000);
    send_word(10'd1000, 10'd1023);
    send_word(10'd999, 10'd0);
    send_word(10'd0, 10'd999);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 100 == 0) steady = ($urandom_range(0, 3) == 0);
      send_word(random_value(), random_value());
    end
    value_if.valid <= 1'b0;
    steady = 1'b0;

    while (board.waiting() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/ddss_pkg.sv
hw/rtl/ddss_value_if.sv
hw/rtl/ddss_digit_if.sv
hw/rtl/ddss_bcd_cell.sv
hw/rtl/dual_decimal_seven_segment_scanner_core.sv
tb/testbench.sv
